// ===== src/isp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants for the image stream pixel parser.
// ----------------------------------------------------------------------------
package isp_pkg;

  typedef enum logic [3:0] {
    PH_START,
    PH_W_HI,
    PH_W_LO,
    PH_H_HI,
    PH_H_LO,
    PH_AMODE,
    PH_SKIP,
    PH_PIX_A,
    PH_PIX_R,
    PH_PIX_G,
    PH_PIX_B,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

  localparam logic [7:0] ALPHA_MODE_ON = 8'h01;
  localparam logic [7:0] ALPHA_CLEAR   = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One parsed event as it travels from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
    logic [31:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_pixel;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/isp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_in_if / isp_out_if
// Valid/ready channels for raw stream bytes and for parsed results.
// ----------------------------------------------------------------------------
interface isp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface isp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] width;
  logic [15:0] height;
  logic        has_alpha;
  logic [31:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last_pixel;

  modport source (output valid, kind, width, height, has_alpha, pixel_index,
                  red, green, blue, alpha, last_pixel, input ready);
  modport sink   (input valid, kind, width, height, has_alpha, pixel_index,
                  red, green, blue, alpha, last_pixel, output ready);
endinterface

// ===== src/image_stream_pixel_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_stream_pixel_parser_core
// Parses an image byte stream into a header result and RGBA pixel results.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stream byte per transfer plus a restart flag that marks
//   the first byte of a new image. out_ch carries one result per header,
//   pixel or bad start marker. cfg_we/cfg_index/cfg_data write the start
//   marker (index 0) and the end marker (index 1); write them while idle.
//   The parser takes one byte per clock while in_ch.ready is high. A byte
//   that completes a result goes through the queue to out_ch: the front
//   end posts an event into a two-entry queue, and the back end moves it
//   into the output register when that register is empty or being taken.
//   in_ch.ready drops only while the queue is full, which happens when the
//   receiver stalls; the output register then holds its result until it is
//   taken. Bytes that make no result are absorbed.
//   The pixel total is a registered 16x16 product of width and height.
//   Synchronous reset clears the parser, the queue, the output valid flag
//   and both markers; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module image_stream_pixel_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [isp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  isp_in_if.sink                         in_ch,
  isp_out_if.source                      out_ch
);
  import isp_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  op_t       push_op, pop_op, res;
  logic      res_valid;

  isp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (in_ch.valid),
    .byte_data    (in_ch.data_byte),
    .byte_restart (in_ch.restart),
    .byte_ready   (in_ch.ready),
    .q_status     (q_status),
    .push         (push),
    .push_op      (push_op)
  );

  isp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .status  (q_status)
  );

  isp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_op      (pop_op),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.kind        = res.kind;
  assign out_ch.width       = res.width;
  assign out_ch.height      = res.height;
  assign out_ch.has_alpha   = res.has_alpha;
  assign out_ch.pixel_index = res.pixel_index;
  assign out_ch.red         = res.red;
  assign out_ch.green       = res.green;
  assign out_ch.blue        = res.blue;
  assign out_ch.alpha       = res.alpha;
  assign out_ch.last_pixel  = res.last_pixel;
endmodule

// ===== src/isp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_front
// Byte parser: tracks the header, collects pixel bytes and posts events.
// ----------------------------------------------------------------------------
module isp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [isp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           byte_valid,
  input  logic [7:0]                     byte_data,
  input  logic                           byte_restart,
  output logic                           byte_ready,
  input  isp_pkg::q_status_t             q_status,
  output logic                           push,
  output isp_pkg::op_t                   push_op
);
  import isp_pkg::*;

  logic [7:0]  start_marker_r, end_marker_r;
  phase_t      phase_r, phase_nxt, phase_eff;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        amode_r, amode_nxt;
  logic [31:0] total_r;
  logic [31:0] count_r, count_nxt;
  logic [7:0]  pend_a_r, pend_a_nxt;
  logic [7:0]  pend_r_r, pend_r_nxt;
  logic [7:0]  pend_g_r, pend_g_nxt;
  logic        accept;
  logic        last;
  logic        empty_image;

  assign byte_ready  = !q_status.full;
  assign accept      = byte_valid && byte_ready;
  assign phase_eff   = byte_restart ? PH_START : phase_r;
  assign last        = (count_r == (total_r - 32'd1));
  assign empty_image = (width_r == 16'd0) || (height_r == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= '0;
      end_marker_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker_r <= cfg_data;
        CFG_END_MARKER:   end_marker_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_eff)
        PH_START: phase_nxt = (byte_data == start_marker_r) ? PH_W_HI : PH_ERROR;
        PH_W_HI:  phase_nxt = PH_W_LO;
        PH_W_LO:  phase_nxt = PH_H_HI;
        PH_H_HI:  phase_nxt = PH_H_LO;
        PH_H_LO:  phase_nxt = PH_AMODE;
        PH_AMODE: phase_nxt = PH_SKIP;
        PH_SKIP: begin
          if (byte_data == end_marker_r) begin
            if (empty_image) phase_nxt = PH_DONE;
            else             phase_nxt = amode_r ? PH_PIX_A : PH_PIX_R;
          end
        end
        PH_PIX_A: begin
          if (byte_data == ALPHA_CLEAR) phase_nxt = last ? PH_DONE : PH_PIX_A;
          else                          phase_nxt = PH_PIX_R;
        end
        PH_PIX_R: phase_nxt = PH_PIX_G;
        PH_PIX_G: phase_nxt = PH_PIX_B;
        PH_PIX_B: begin
          if (last) phase_nxt = PH_DONE;
          else      phase_nxt = amode_r ? PH_PIX_A : PH_PIX_R;
        end
        default:  phase_nxt = phase_eff;
      endcase
    end
  end

  // Event posted to the queue.
  always_comb begin
    push                 = 1'b0;
    push_op              = '0;
    push_op.kind         = KIND_PIXEL;
    push_op.width        = width_r;
    push_op.height       = height_r;
    push_op.has_alpha    = amode_r;
    push_op.pixel_index  = count_r;
    push_op.last_pixel   = last;
    if (accept) begin
      unique case (phase_eff)
        PH_START: begin
          push         = (byte_data != start_marker_r);
          push_op.kind = KIND_ERROR;
        end
        PH_SKIP: begin
          push         = (byte_data == end_marker_r);
          push_op.kind = KIND_HEADER;
        end
        PH_PIX_A: begin
          // A fully transparent pixel carries no colour bytes.
          push          = (byte_data == ALPHA_CLEAR);
          push_op.alpha = ALPHA_CLEAR;
        end
        PH_PIX_B: begin
          push          = 1'b1;
          push_op.red   = pend_r_r;
          push_op.green = pend_g_r;
          push_op.blue  = byte_data;
          push_op.alpha = pend_a_r;
        end
        default: push = 1'b0;
      endcase
    end
  end

  // Header fields, pixel counter and pending colour bytes.
  always_comb begin
    width_nxt  = byte_restart ? 16'd0 : width_r;
    height_nxt = byte_restart ? 16'd0 : height_r;
    amode_nxt  = byte_restart ? 1'b0  : amode_r;
    count_nxt  = byte_restart ? 32'd0 : count_r;
    pend_a_nxt = byte_restart ? 8'd0  : pend_a_r;
    pend_r_nxt = byte_restart ? 8'd0  : pend_r_r;
    pend_g_nxt = byte_restart ? 8'd0  : pend_g_r;
    unique case (phase_eff)
      PH_W_HI:  width_nxt  = {byte_data, 8'd0};
      PH_W_LO:  width_nxt  = {width_r[15:8], byte_data};
      PH_H_HI:  height_nxt = {byte_data, 8'd0};
      PH_H_LO:  height_nxt = {height_r[15:8], byte_data};
      PH_AMODE: amode_nxt  = (byte_data == ALPHA_MODE_ON);
      PH_SKIP:  if (byte_data == end_marker_r) count_nxt = 32'd0;
      PH_PIX_A: begin
        if (byte_data == ALPHA_CLEAR) count_nxt = count_r + 32'd1;
        else                          pend_a_nxt = byte_data;
      end
      PH_PIX_R: pend_r_nxt = byte_data;
      PH_PIX_G: pend_g_nxt = byte_data;
      PH_PIX_B: count_nxt  = count_r + 32'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      width_r  <= '0;
      height_r <= '0;
      amode_r  <= 1'b0;
      count_r  <= '0;
      pend_a_r <= '0;
      pend_r_r <= '0;
      pend_g_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (accept) begin
        width_r  <= width_nxt;
        height_r <= height_nxt;
        amode_r  <= amode_nxt;
        count_r  <= count_nxt;
        pend_a_r <= pend_a_nxt;
        pend_r_r <= pend_r_nxt;
        pend_g_r <= pend_g_nxt;
      end
    end
  end

  // Width and height settle at least one transfer before the end marker, so
  // the registered product is ready by the first pixel.
  always_ff @(posedge clk) begin
    total_r <= 32'(width_r) * 32'(height_r);
  end

`ifndef SYNTHESIS
  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_op.kind == KIND_PIXEL && push_op.last_pixel |=> phase_r == PH_DONE)
    else $error("last pixel did not end the image");
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("event posted to a full queue");
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR && !(accept && byte_restart) |=> phase_r == PH_ERROR)
    else $error("error phase left without restart");
`endif
endmodule

// ===== src/isp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_queue
// Short FIFO of parsed events between the front end and the back end.
// ----------------------------------------------------------------------------
module isp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  isp_pkg::op_t        push_op,
  input  logic                pop,
  output isp_pkg::op_t        pop_op,
  output isp_pkg::q_status_t  status
);
  import isp_pkg::*;

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign pop_op       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    priority if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push)     count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif
endmodule

// ===== src/isp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_back
// Formats queued events into result items and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
module isp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  isp_pkg::q_status_t  q_status,
  input  isp_pkg::op_t        q_op,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output isp_pkg::op_t        res
);
  import isp_pkg::*;

  logic valid_r;
  op_t  res_r, res_nxt;

  assign pop       = !q_status.empty && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    res_nxt = '0;
    unique case (q_op.kind)
      KIND_PIXEL: begin
        res_nxt       = q_op;
        // Without alpha mode every pixel is opaque.
        res_nxt.alpha = q_op.has_alpha ? q_op.alpha : ALPHA_OPAQUE;
      end
      KIND_HEADER: begin
        res_nxt.kind      = KIND_HEADER;
        res_nxt.width     = q_op.width;
        res_nxt.height    = q_op.height;
        res_nxt.has_alpha = q_op.has_alpha;
      end
      KIND_ERROR: res_nxt.kind = KIND_ERROR;
      default:    res_nxt.kind = KIND_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         valid_r <= 1'b0;
    else if (pop)       valid_r <= 1'b1;
    else if (res_ready) valid_r <= 1'b0;
  end

`ifndef SYNTHESIS
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped event not presented");
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.kind == KIND_ERROR |-> res_r.width == '0 && res_r.height == '0)
    else $error("error result carries header fields");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_ready |-> !pop)
    else $error("output register overwritten while stalled");
`endif
endmodule

// ===== tb/image_stream_pixel_parser_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_stream_pixel_parser_core_test
// Self-checking bench for the image stream parser: a clocked driver feeds
// stream bytes from a queue and keeps a model of the header and pixel
// decoder, and a clocked monitor compares every result with that model.
// ----------------------------------------------------------------------------
module image_stream_pixel_parser_core_test;
  import isp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       restart;
  } stream_byte_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  isp_in_if  in_ch ();
  isp_out_if out_ch ();

  image_stream_pixel_parser_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  stream_byte_t stream_bytes[$];
  op_t          expected_results[$];
  int           queued_total;
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  // Model of the parser.
  logic [7:0]  start_mark;
  logic [7:0]  end_mark;
  phase_t      img_phase;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic        img_alpha;
  logic [31:0] img_total;
  logic [31:0] img_count;
  logic [7:0]  held_alpha;
  logic [7:0]  held_red;
  logic [7:0]  held_green;

  function automatic op_t next_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a);
    op_t px;
    px             = '0;
    px.kind        = KIND_PIXEL;
    px.width       = img_width;
    px.height      = img_height;
    px.has_alpha   = img_alpha;
    px.pixel_index = img_count;
    px.red         = r;
    px.green       = g;
    px.blue        = b;
    px.alpha       = a;
    px.last_pixel  = (img_count == img_total - 32'd1);
    img_count++;
    if (img_count >= img_total) begin
      img_phase = PH_DONE;
    end else if (img_alpha) begin
      img_phase = PH_PIX_A;
    end else begin
      img_phase = PH_PIX_R;
    end
    return px;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic rs);
    op_t res;
    bit  emit;
    res  = '0;
    emit = 1'b0;
    if (rs) begin
      img_phase  = PH_START;
      img_width  = '0;
      img_height = '0;
      img_alpha  = 1'b0;
      img_total  = '0;
      img_count  = '0;
      held_alpha = '0;
      held_red   = '0;
      held_green = '0;
    end
    case (img_phase)
      PH_START: begin
        if (b == start_mark) begin
          img_phase = PH_W_HI;
        end else begin
          img_phase = PH_ERROR;
          res.kind  = KIND_ERROR;
          emit      = 1'b1;
        end
      end
      PH_W_HI: begin
        img_width = {b, 8'h00};
        img_phase = PH_W_LO;
      end
      PH_W_LO: begin
        img_width[7:0] = b;
        img_phase      = PH_H_HI;
      end
      PH_H_HI: begin
        img_height = {b, 8'h00};
        img_phase  = PH_H_LO;
      end
      PH_H_LO: begin
        img_height[7:0] = b;
        img_phase       = PH_AMODE;
      end
      PH_AMODE: begin
        img_alpha = (b == ALPHA_MODE_ON);
        img_phase = PH_SKIP;
      end
      PH_SKIP: begin
        if (b == end_mark) begin
          img_total = 32'(img_width) * 32'(img_height);
          img_count = '0;
          if (img_total == 0) begin
            img_phase = PH_DONE;
          end else if (img_alpha) begin
            img_phase = PH_PIX_A;
          end else begin
            img_phase = PH_PIX_R;
          end
          res.kind      = KIND_HEADER;
          res.width     = img_width;
          res.height    = img_height;
          res.has_alpha = img_alpha;
          emit          = 1'b1;
        end
      end
      PH_PIX_A: begin
        if (b == ALPHA_CLEAR) begin
          res  = next_pixel(8'h00, 8'h00, 8'h00, 8'h00);
          emit = 1'b1;
        end else begin
          held_alpha = b;
          img_phase  = PH_PIX_R;
        end
      end
      PH_PIX_R: begin
        held_red  = b;
        img_phase = PH_PIX_G;
      end
      PH_PIX_G: begin
        held_green = b;
        img_phase  = PH_PIX_B;
      end
      PH_PIX_B: begin
        res  = next_pixel(held_red, held_green, b, img_alpha ? held_alpha : ALPHA_OPAQUE);
        emit = 1'b1;
      end
      default: ;
    endcase
    if (emit) expected_results.push_back(res);
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic rs);
    stream_byte_t sb;
    sb.data    = data;
    sb.restart = rs;
    stream_bytes.push_back(sb);
    queued_total++;
  endfunction

  // Random byte that differs from the given value.
  function automatic logic [7:0] other_than(input logic [7:0] v);
    int x;
    x = $urandom_range(0, 254);
    if (x >= v) x++;
    return 8'(x);
  endfunction

  // Queues one image: mostly well formed, sometimes cut short, padded with
  // surplus bytes, opened with a bad marker, or replaced by plain noise.
  function automatic void add_image();
    int          roll;
    bit          wide;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  amode;
    logic [7:0]  a;
    logic [31:0] total;
    logic [31:0] n_pix;
    roll = $urandom_range(0, 99);
    if (roll < 7) begin
      push_byte(other_than(start_mark), 1'b1);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
      return;
    end
    if (roll < 13) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 99) < 30);
      return;
    end
    wide = ($urandom_range(0, 99) < 10);
    if (wide) begin
      w = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      h = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      w = ($urandom_range(0, 99) < 6) ? 16'd0 : 16'($urandom_range(1, 4));
      h = ($urandom_range(0, 99) < 6) ? 16'd0 : 16'($urandom_range(1, 4));
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      amode = ALPHA_MODE_ON;
    end else if (roll < 70) begin
      amode = 8'h00;
    end else begin
      amode = 8'($urandom);
    end
    push_byte(start_mark, 1'b1);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b0);
    push_byte(h[15:8], 1'b0);
    push_byte(h[7:0], 1'b0);
    push_byte(amode, 1'b0);
    repeat ($urandom_range(0, 3)) push_byte(other_than(end_mark), 1'b0);
    push_byte(end_mark, 1'b0);
    total = 32'(w) * 32'(h);
    n_pix = total;
    if (wide && total > 5) begin
      n_pix = $urandom_range(1, 5);
    end else if (total > 0 && $urandom_range(0, 99) < 10) begin
      n_pix = $urandom_range(0, total - 1);
    end
    for (int i = 0; i < n_pix; i++) begin
      if (amode == ALPHA_MODE_ON) begin
        a = ($urandom_range(0, 99) < 25) ? ALPHA_CLEAR : 8'($urandom_range(1, 255));
        push_byte(a, 1'b0);
        if (a == ALPHA_CLEAR) continue;
      end
      repeat (3) push_byte(8'($urandom), 1'b0);
    end
    // A partial pixel when the image was cut short.
    if (n_pix < total && $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 2)) push_byte(8'($urandom), 1'b0);
    end
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (stream_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0);
  endtask

  task automatic run_phase(input logic [7:0] sm, input logic [7:0] em, input int idle,
                           input int stall, input int n, input bit pause);
    int first;
    wait_drained();
    // Bytes that make no result may still be in the pipeline.
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data  <= sm;
    @(posedge clk);
    cfg_index <= CFG_END_MARKER;
    cfg_data  <= em;
    @(posedge clk);
    cfg_we     <= 1'b0;
    start_mark = sm;
    end_mark   = em;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    first = queued_total;
    while (queued_total - first < n) begin
      add_image();
      if (pause && queued_total - first >= n / 2) begin
        wait_drained();
        pause = 1'b0;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: one byte per transfer; valid holds until the byte is taken.
  always @(posedge clk) begin : drive_bytes
    stream_byte_t sb;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.restart);
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current byte.
      end else if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sb = stream_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= sb.data;
        in_ch.restart   <= sb.restart;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin : collect_results
    op_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d, pixel_index %0d", out_ch.kind,
                 out_ch.pixel_index);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("width", want.width, out_ch.width);
          check_field("height", want.height, out_ch.height);
          check_field("has_alpha", want.has_alpha, out_ch.has_alpha);
          check_field("pixel_index", want.pixel_index, out_ch.pixel_index);
          check_field("red", want.red, out_ch.red);
          check_field("green", want.green, out_ch.green);
          check_field("blue", want.blue, out_ch.blue);
          check_field("alpha", want.alpha, out_ch.alpha);
          check_field("last_pixel", want.last_pixel, out_ch.last_pixel);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_START_MARKER;
    cfg_data        = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.restart   = 1'b0;
    out_ch.ready    = 1'b0;
    queued_total    = 0;
    mismatch_count  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    start_mark      = 8'h00;
    end_mark        = 8'h00;
    img_phase       = PH_START;
    img_width       = '0;
    img_height      = '0;
    img_alpha       = 1'b0;
    img_total       = '0;
    img_count       = '0;
    held_alpha      = '0;
    held_red        = '0;
    held_green      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with both markers at their reset value of zero.
    push_byte(8'h5A, 1'b1);                   // bad start marker
    push_byte(8'h00, 1'b0);                   // ignored after the error
    push_byte(8'h00, 1'b1);                   // 1 x 2 image with alpha
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(ALPHA_MODE_ON, 1'b0);
    push_byte(8'h33, 1'b0);                   // skipped metadata
    push_byte(8'h00, 1'b0);                   // end marker
    push_byte(ALPHA_CLEAR, 1'b0);             // black pixel, no colour bytes
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7E, 1'b0);                   // last pixel
    push_byte(8'hFF, 1'b0);                   // surplus byte
    push_byte(8'h00, 1'b1);                   // empty image, 0 x 5
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h11, 1'b0);                   // ignored, image is empty

    run_phase(8'h00, 8'hFF, 0, 0, 230, 1'b0);
    run_phase(8'hFF, 8'h00, 57, 0, 230, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 0, 57, 230, 1'b1);
    run_phase(8'h7E, 8'h7E, 13, 13, 230, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 0, 0, 230, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 57, 0, 230, 1'b0);
    run_phase(8'hFF, 8'hFF, 0, 57, 230, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 13, 13, 230, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("image_stream_pixel_parser_core_test passed");
    end else begin
      $display("image_stream_pixel_parser_core_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("image_stream_pixel_parser_core_test failed");
    $finish;
  end

endmodule
